// ----- rtl/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int OP_W  = 4;

    localparam logic [OP_W-1:0] OP_NORM  = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
    localparam logic [OP_W-1:0] OP_NEG   = 4'd5;
    localparam logic [OP_W-1:0] OP_SQR   = 4'd6;
    localparam logic [OP_W-1:0] OP_RECIP = 4'd7;
    localparam logic [OP_W-1:0] OP_EQ    = 4'd8;
    localparam logic [OP_W-1:0] OP_GT    = 4'd9;

    // which fraction the reducer is working on
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_A,
        SEL_B,
        SEL_R
    } red_sel_t;

    typedef struct packed {
        logic     load;
        logic     red_start;
        red_sel_t sel;
        logic     mul_en;
        logic     comb_en;
        logic     res_en;
    } rau_cmd_t;

    typedef struct packed {
        logic red_done;
    } rau_status_t;

endpackage

// ----- rtl/rau_reduce.sv -----
// Fraction reducer: sign to numerator, binary gcd, two restoring dividers.
// Depends on nothing outside this file.
module rau_reduce #(
    parameter int P = 34
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [P-1:0] n_in,
    input  logic signed [P-1:0] d_in,
    output logic                done,
    output logic signed [P-1:0] n_out,
    output logic        [P-1:0] d_out
);
    localparam int KW = $clog2(P + 1);
    localparam int CW = $clog2(P);

    typedef enum logic [1:0] {
        R_IDLE,
        R_GCD,
        R_DIV
    } phase_t;

    phase_t                phase_reg;
    logic        [P-1:0]   x_reg, y_reg, g_reg;
    logic        [KW-1:0]  k_reg;
    logic                  neg_reg;
    logic        [P-1:0]   q1_reg, q2_reg, r1_reg, r2_reg;
    logic        [CW-1:0]  cnt_reg;
    logic                  done_reg;
    logic signed [P-1:0]   n_out_reg;
    logic        [P-1:0]   d_out_reg;

    logic [P-1:0] mn, md;
    logic [P:0]   t1, t2;
    logic         ge1, ge2;
    logic [P-1:0] r1_next, r2_next, q1_next, q2_next;

    always_comb
    begin
        mn = n_in[P-1] ? P'(-n_in) : P'(n_in);
        md = d_in[P-1] ? P'(-d_in) : P'(d_in);
        t1 = {r1_reg, q1_reg[P-1]};
        t2 = {r2_reg, q2_reg[P-1]};
        ge1 = t1 >= {1'b0, g_reg};
        ge2 = t2 >= {1'b0, g_reg};
        r1_next = ge1 ? P'(t1 - {1'b0, g_reg}) : P'(t1);
        r2_next = ge2 ? P'(t2 - {1'b0, g_reg}) : P'(t2);
        q1_next = {q1_reg[P-2:0], ge1};
        q2_next = {q2_reg[P-2:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= R_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            g_reg     <= '0;
            k_reg     <= '0;
            neg_reg   <= 1'b0;
            q1_reg    <= '0;
            q2_reg    <= '0;
            r1_reg    <= '0;
            r2_reg    <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            n_out_reg <= '0;
            d_out_reg <= P'(1);
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        if (n_in == '0 || d_in == '0)
                        begin
                            n_out_reg <= '0;
                            d_out_reg <= P'(1);
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            neg_reg   <= n_in[P-1] ^ d_in[P-1];
                            x_reg     <= mn;
                            y_reg     <= md;
                            q1_reg    <= mn;
                            q2_reg    <= md;
                            k_reg     <= '0;
                            phase_reg <= R_GCD;
                        end
                    end
                end
                R_GCD:
                begin
                    // Stein's algorithm, one step a cycle; y never reaches zero
                    if (x_reg == '0)
                    begin
                        g_reg     <= y_reg << k_reg;
                        r1_reg    <= '0;
                        r2_reg    <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= R_DIV;
                    end
                    else if (!x_reg[0] && !y_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + KW'(1);
                    end
                    else if (!x_reg[0])
                        x_reg <= x_reg >> 1;
                    else if (!y_reg[0])
                        y_reg <= y_reg >> 1;
                    else if (x_reg >= y_reg)
                        x_reg <= x_reg - y_reg;
                    else
                        y_reg <= y_reg - x_reg;
                end
                R_DIV:
                begin
                    r1_reg  <= r1_next;
                    r2_reg  <= r2_next;
                    q1_reg  <= q1_next;
                    q2_reg  <= q2_next;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(P - 1))
                    begin
                        n_out_reg <= neg_reg ? -$signed(q1_next) : $signed(q1_next);
                        d_out_reg <= q2_next;
                        done_reg  <= 1'b1;
                        phase_reg <= R_IDLE;
                    end
                end
                default:
                    phase_reg <= R_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign n_out = n_out_reg;
    assign d_out = d_out_reg;

`ifndef ASSERT_OFF
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> d_out != '0)
        else $error("reduced denominator is zero");
    a_gcd_y_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == R_GCD |-> y_reg != '0)
        else $error("gcd operand collapsed to zero");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("reducer done held for two cycles");
`endif
endmodule

// ----- rtl/rau_datapath.sv -----
// Datapath: operand registers, product stage, op combine, reducer, result words.
// Depends on rau_pkg and rau_reduce.
module rau_datapath #(
    parameter int W = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rau_pkg::rau_cmd_t          cmd,
    output rau_pkg::rau_status_t       status,
    input  logic [rau_pkg::OP_W-1:0]   op,
    input  logic signed [W-1:0]        a_num,
    input  logic signed [W-1:0]        a_den,
    input  logic signed [W-1:0]        b_num,
    input  logic signed [W-1:0]        b_den,
    output logic signed [rau_pkg::NUM_W-1:0] res_num,
    output logic [rau_pkg::DEN_W-1:0]  res_den,
    output logic                       cmp_true,
    output logic                       div_zero
);
    import rau_pkg::*;

    localparam int AW = W + 1;
    localparam int P  = 2 * W + 2;

    logic [OP_W-1:0]     op_reg;
    logic signed [W-1:0] ra_n_reg, ra_d_reg, rb_n_reg, rb_d_reg;
    logic signed [AW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [P-1:0] m1_reg, m2_reg, m3_reg;
    logic signed [P-1:0] n_reg, d_reg;
    logic                cmp_reg, dz_reg;
    logic signed [NUM_W-1:0] res_num_reg;
    logic [DEN_W-1:0]    res_den_reg;
    logic                cmp_out_reg, dz_out_reg;

    logic signed [AW-1:0] y1, x2;
    logic signed [P-1:0]  red_n_in, red_d_in, red_n;
    logic [P-1:0]         red_d;
    logic                 red_done;
    logic signed [P-1:0]  n_next, d_next;
    logic                 cmp_next, dz_next;

    rau_reduce #(.P(P)) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.red_start),
        .n_in  (red_n_in),
        .d_in  (red_d_in),
        .done  (red_done),
        .n_out (red_n),
        .d_out (red_d)
    );

    always_comb
    begin
        unique case (cmd.sel)
            SEL_A:
            begin
                red_n_in = P'(ra_n_reg);
                red_d_in = P'(ra_d_reg);
            end
            SEL_B:
            begin
                red_n_in = P'(rb_n_reg);
                red_d_in = P'(rb_d_reg);
            end
            SEL_R:
            begin
                red_n_in = n_reg;
                red_d_in = d_reg;
            end
            default:
            begin
                red_n_in = '0;
                red_d_in = '0;
            end
        endcase
    end

    // multiplicand choice: m1 = an*y1, m2 = x2*ad, m3 = ad*bd
    always_comb
    begin
        if (op_reg == OP_MUL)
            y1 = bn_reg;
        else if (op_reg == OP_SQR)
            y1 = an_reg;
        else
            y1 = bd_reg;
        x2 = (op_reg == OP_SQR) ? ad_reg : bn_reg;
    end

    always_comb
    begin
        n_next   = '0;
        d_next   = P'(1);
        cmp_next = 1'b0;
        dz_next  = 1'b0;
        unique case (op_reg)
            OP_NORM:
            begin
                n_next = P'(an_reg);
                d_next = P'(ad_reg);
            end
            OP_ADD:
            begin
                n_next = m1_reg + m2_reg;
                d_next = m3_reg;
            end
            OP_SUB:
            begin
                n_next = m1_reg - m2_reg;
                d_next = m3_reg;
            end
            OP_MUL:
            begin
                n_next = m1_reg;
                d_next = m3_reg;
            end
            OP_DIV:
            begin
                if (bn_reg == '0)
                    dz_next = 1'b1;
                else
                begin
                    n_next = m1_reg;
                    d_next = m2_reg;
                end
            end
            OP_NEG:
            begin
                n_next = -P'(an_reg);
                d_next = P'(ad_reg);
            end
            OP_SQR:
            begin
                n_next = m1_reg;
                d_next = m2_reg;
            end
            OP_RECIP:
            begin
                if (an_reg == '0)
                    dz_next = 1'b1;
                else
                begin
                    n_next = P'(ad_reg);
                    d_next = P'(an_reg);
                end
            end
            OP_EQ:
                cmp_next = m1_reg == m2_reg;
            OP_GT:
                cmp_next = m1_reg > m2_reg;
            default:
            begin
                n_next = '0;
                d_next = P'(1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            ra_n_reg <= a_num;
            ra_d_reg <= a_den;
            rb_n_reg <= b_num;
            rb_d_reg <= b_den;
        end
        if (red_done && cmd.sel == SEL_A)
        begin
            an_reg <= AW'(red_n);
            ad_reg <= AW'(red_d);
        end
        if (red_done && cmd.sel == SEL_B)
        begin
            bn_reg <= AW'(red_n);
            bd_reg <= AW'(red_d);
        end
        if (cmd.mul_en)
        begin
            m1_reg <= an_reg * y1;
            m2_reg <= x2 * ad_reg;
            m3_reg <= ad_reg * bd_reg;
        end
        if (cmd.comb_en)
        begin
            n_reg   <= n_next;
            d_reg   <= d_next;
            cmp_reg <= cmp_next;
            dz_reg  <= dz_next;
        end
        if (cmd.res_en)
        begin
            res_num_reg <= NUM_W'(red_n);
            res_den_reg <= DEN_W'(red_d);
            cmp_out_reg <= cmp_reg;
            dz_out_reg  <= dz_reg;
        end
    end

    assign status.red_done = red_done;
    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign cmp_true = cmp_out_reg;
    assign div_zero = dz_out_reg;
endmodule

// ----- rtl/rau_ctrl.sv -----
// Sequencer: reduce a, reduce b, multiply, combine, reduce result, strobe.
// Depends on rau_pkg.
module rau_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output rau_pkg::rau_cmd_t    cmd,
    input  rau_pkg::rau_status_t status
);
    import rau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RA,
        S_RB,
        S_MUL,
        S_COMB,
        S_RR
    } state_t;

    state_t state_reg;
    logic   red_start_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            red_start_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            red_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        state_reg     <= S_RA;
                        red_start_reg <= 1'b1;
                    end
                S_RA:
                    if (status.red_done)
                    begin
                        state_reg     <= S_RB;
                        red_start_reg <= 1'b1;
                    end
                S_RB:
                    if (status.red_done)
                        state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_COMB;
                S_COMB:
                begin
                    state_reg     <= S_RR;
                    red_start_reg <= 1'b1;
                end
                S_RR:
                    if (status.red_done)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.red_start = red_start_reg;
        unique case (state_reg)
            S_RA:    cmd.sel = SEL_A;
            S_RB:    cmd.sel = SEL_B;
            S_RR:    cmd.sel = SEL_R;
            default: cmd.sel = SEL_NONE;
        endcase
        cmd.mul_en  = state_reg == S_MUL;
        cmd.comb_en = state_reg == S_COMB;
        cmd.res_en  = (state_reg == S_RR) && status.red_done;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

`ifndef ASSERT_OFF
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result strobe while sequencer busy");
    a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
        start && state_reg == S_IDLE |=> state_reg == S_RA && red_start_reg)
        else $error("accepted word did not start operand reduction");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.red_done |-> state_reg == S_RA || state_reg == S_RB || state_reg == S_RR)
        else $error("reducer finished outside a wait state");
`endif
endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: sequencer plus datapath.
// Depends on rau_pkg, rau_ctrl, rau_datapath (and rau_reduce beneath it).
//
//   channel  | handshake           | words
//   ---------+---------------------+-------------------------------------------
//   command  | start / busy        | op, a_num, a_den, b_num, b_den
//   result   | done (1-cycle)      | res_num, res_den, cmp_true, div_zero
//
// One word at a time. The shared reducer runs three times (a, b, result); each
// run is a binary gcd, then a restoring divide over P = 2*OPERAND_WIDTH+2
// bits; zero operands and zero results skip their reductions. Reset clears
// the sequencer and reducer only. The receiver cannot stall: done is high
// for one cycle, and busy is already low in that cycle.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rau_pkg::OP_W-1:0]          op,
    input  logic signed [OPERAND_WIDTH-1:0]   a_num,
    input  logic signed [OPERAND_WIDTH-1:0]   a_den,
    input  logic signed [OPERAND_WIDTH-1:0]   b_num,
    input  logic signed [OPERAND_WIDTH-1:0]   b_den,
    output logic                              done,
    output logic signed [rau_pkg::NUM_W-1:0]  res_num,
    output logic [rau_pkg::DEN_W-1:0]         res_den,
    output logic                              cmp_true,
    output logic                              div_zero
);
    import rau_pkg::*;

    rau_cmd_t    cmd;
    rau_status_t status;

    rau_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    rau_datapath #(.W(OPERAND_WIDTH)) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .op       (op),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .res_num  (res_num),
        .res_den  (res_den),
        .cmp_true (cmp_true),
        .div_zero (div_zero)
    );
endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for rational_arithmetic_unit: random and directed fraction words.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
`timescale 1ns / 100ps

module testbench;
    import rau_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [15:0]     an;
        logic [15:0]     ad;
        logic [15:0]     bn;
        logic [15:0]     bd;
    } frac_word_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             cmp;
        logic             dz;
    } frac_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_W-1:0] op = '0;
    logic signed [15:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
    logic done;
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0] res_den;
    logic cmp_true, div_zero;

    frac_word_t pending_words[$];
    frac_res_t  expected_fracs[$];
    int errors = 0;
    int gap_left = 0;
    bit calm = 0;
    bit feeding = 1;

    rational_arithmetic_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .done(done), .res_num(res_num), .res_den(res_den),
        .cmp_true(cmp_true), .div_zero(div_zero)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // sign to numerator, zero as 0/1, reduce
    function automatic void canonical(input longint n, input longint d, output longint rn,
                                      output longint rd);
        longint unsigned g;
        if (n == 0 || d == 0)
        begin
            rn = 0;
            rd = 1;
        end
        else
        begin
            if (d < 0)
            begin
                n = -n;
                d = -d;
            end
            g = gcd_of(n < 0 ? -n : n, d);
            rn = n / longint'(g);
            rd = d / longint'(g);
        end
    endfunction

    function automatic frac_res_t rational_result(frac_word_t w);
        longint an, ad, bn, bd, n, d, rn, rd;
        frac_res_t r;
        r.cmp = 0;
        r.dz = 0;
        n = 0;
        d = 1;
        canonical(longint'(signed'(w.an)), longint'(signed'(w.ad)), an, ad);
        canonical(longint'(signed'(w.bn)), longint'(signed'(w.bd)), bn, bd);
        case (w.op)
            OP_NORM:  begin n = an; d = ad; end
            OP_ADD:   begin n = an * bd + bn * ad; d = ad * bd; end
            OP_SUB:   begin n = an * bd - bn * ad; d = ad * bd; end
            OP_MUL:   begin n = an * bn; d = ad * bd; end
            OP_DIV:
                if (bn == 0) r.dz = 1;
                else begin n = an * bd; d = ad * bn; end
            OP_NEG:   begin n = -an; d = ad; end
            OP_SQR:   begin n = an * an; d = ad * ad; end
            OP_RECIP:
                if (an == 0) r.dz = 1;
                else begin n = ad; d = an; end
            OP_EQ:    r.cmp = (an * bd == bn * ad);
            OP_GT:    r.cmp = (an * bd > bn * ad);
            default:  ;
        endcase
        canonical(n, d, rn, rd);
        r.num = rn[NUM_W-1:0];
        r.den = rd[DEN_W-1:0];
        return r;
    endfunction

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'($urandom_range(0, 8)) - 4);
            3: return 16'($urandom_range(0, 40)) - 16'd20;
            4: return 16'($urandom_range(0, 600)) - 16'd300;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_word(input logic [OP_W-1:0] o, input logic [15:0] an,
                              input logic [15:0] ad, input logic [15:0] bn,
                              input logic [15:0] bd);
        frac_word_t w;
        w = '{op: o, an: an, ad: ad, bn: bn, bd: bd};
        pending_words = {pending_words, w};
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_fracs = {expected_fracs, rational_result(
                    '{op: op, an: a_num, ad: a_den, bn: b_num, bd: b_den})};
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                gap_left <= $urandom_range(0, 2);
                start <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                frac_word_t w;
                w = pending_words.pop_front();
                op <= w.op;
                a_num <= w.an;
                a_den <= w.ad;
                b_num <= w.bn;
                b_den <= w.bd;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
                feeding <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        frac_res_t e;
        if (rst_n && done)
        begin
            if (expected_fracs.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_fracs.pop_front();
                if (res_num !== e.num)
                begin
                    $error("res_num exp %0d got %0d", signed'(e.num), res_num);
                    errors++;
                end
                if (res_den !== e.den)
                begin
                    $error("res_den exp %0d got %0d", e.den, res_den);
                    errors++;
                end
                if (cmp_true !== e.cmp)
                begin
                    $error("cmp_true exp %0b got %0b", e.cmp, cmp_true);
                    errors++;
                end
                if (div_zero !== e.dz)
                begin
                    $error("div_zero exp %0b got %0b", e.dz, div_zero);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [OP_W-1:0] o;
        for (int i = 0; i < 16; i++)
        begin
            o = 4'(i);
            queue_word(o, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        end
        queue_word(OP_NORM, 16'd6, 16'hfffc, 16'd0, 16'd0);
        queue_word(OP_NORM, 16'd5, 16'd0, 16'd0, 16'd0);
        queue_word(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd7);
        queue_word(OP_DIV, 16'd3, 16'd4, 16'd5, 16'd0);
        queue_word(OP_RECIP, 16'd0, 16'd9, 16'd1, 16'd1);
        queue_word(OP_SUB, 16'd2, 16'd4, 16'hffff, 16'hfffe);
        queue_word(OP_EQ, 16'd1, 16'd2, 16'd3, 16'd6);
        queue_word(OP_GT, 16'hffff, 16'd2, 16'hffff, 16'd3);
        queue_word(OP_SQR, 16'h8000, 16'h8000, 16'd0, 16'd1);
        for (int i = 0; i < 1100; i++)
        begin
            o = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            queue_word(o, rand_field(), rand_field(), rand_field(), rand_field());
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_words.size() < 100);
        calm = 1;
        wait (!feeding && !busy && expected_fracs.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_fracs.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
